// ===== hdl/psbd_pkg.sv =====
// ----------------------------------------------------------------------------
// Point set box difference - shared package
// Types, codes and constants used by the compare unit, the top-level
// sequencer and the testbench.
// ----------------------------------------------------------------------------
package psbd_pkg;

  // Default sizing handed to the top-level parameters.
  localparam int RefDepthDef   = 1024;
  localparam int CoordBitsDef  = 20;

  // Fixed field widths.
  localparam int TolW          = 10;
  localparam int IntensW       = 16;
  localparam int ReqW          = 2;
  localparam int OutUserW      = 2;

  // A tolerance of 0.1 m expressed in millimetres.
  localparam logic [TolW-1:0] TolReset = TolW'(100);

  // Register file port.
  localparam int ApbAddrW      = 3;
  localparam int ApbDataW      = 32;
  localparam int RegIdxW       = ApbAddrW - 2;
  localparam logic [RegIdxW-1:0] RegTolIdx = RegIdxW'(0);

  typedef enum logic [ReqW-1:0] {
    REQ_LOAD  = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Registered outcome of one comparison by the shared compare unit.
  typedef struct packed {
    logic valid;
    logic hit;
  } cmp_res_t;

endpackage

// ===== hdl/point_set_box_difference.sv =====
// ----------------------------------------------------------------------------
// Point set box difference - top level
// A query reads every stored point from a registered RAM into one compare unit,
// which checks one stored point per cycle; the result then passes through the
// done state into the output register.
// After a load or clear request the next item is taken at once.
// A query holds off new input until its result enters the output register,
// which waits for any earlier result there to drain.
// Reset empties the store, clears the frame flag and sets the tolerance to 100.
// ----------------------------------------------------------------------------
module point_set_box_difference
  import psbd_pkg::*;
#(
  parameter int REF_DEPTH  = RefDepthDef,
  parameter int COORD_BITS = CoordBitsDef,
  localparam int DataW     = ((3 * COORD_BITS + IntensW + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: point_x, point_y, point_z, point_intensity, zero padding
  input  logic [DataW-1:0]    s_axis_tdata,
  // tuser: req_type
  input  logic [ReqW-1:0]     s_axis_tuser,
  input  logic                s_axis_tlast,
  // Result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: out_x, out_y, out_z, out_intensity, zero padding
  output logic [DataW-1:0]    m_axis_tdata,
  // tuser: kept, frame_has_change
  output logic [OutUserW-1:0] m_axis_tuser,
  output logic                m_axis_tlast,
  // Register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int PointW = 3 * COORD_BITS;
  localparam int AddrW  = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
  localparam int CntW   = $clog2(REF_DEPTH + 1);

  state_e              state_q, state_d;
  logic [TolW-1:0]     tol_q;
  logic [CntW-1:0]     ref_count_q, ref_count_d;
  logic [CntW-1:0]     issue_idx_q, issue_idx_d;
  logic                rd_pend_q;
  logic                hit_q, hit_d;
  logic                change_seen_q, change_seen_d;

  logic [PointW-1:0]   query_q;
  logic [IntensW-1:0]  intens_q;
  logic                last_q;

  logic                m_valid_q, m_valid_d;
  logic [DataW-1:0]    m_data_q;
  logic [OutUserW-1:0] m_user_q;
  logic                m_last_q;
  logic                out_load;

  logic                in_fire;
  logic                ram_we;
  logic                rd_en;
  logic [PointW-1:0]   ram_rdata;
  cmp_res_t            cmp_res;
  logic                kept;
  logic                flag;
  logic                cfg_we;

  // --------------------------------------------------------------------------
  // Register port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready &
                  (paddr[ApbAddrW-1:2] == RegTolIdx);
  assign prdata = (paddr[ApbAddrW-1:2] == RegTolIdx) ? ApbDataW'(tol_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolReset;
    end else if (cfg_we) begin
      tol_q <= pwdata[TolW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Reference store and compare unit
  // --------------------------------------------------------------------------
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign ram_we        = in_fire & (s_axis_tuser == REQ_LOAD) &
                         (ref_count_q < CntW'(REF_DEPTH));
  assign rd_en         = (state_q == ST_SCAN) & (issue_idx_q < ref_count_q);

  psbd_ram #(
    .Width (PointW),
    .Depth (REF_DEPTH)
  ) u_ref_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ref_count_q[AddrW-1:0]),
    .wdata_i (s_axis_tdata[PointW-1:0]),
    .re_i    (rd_en),
    .raddr_i (issue_idx_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  psbd_match #(
    .COORD_BITS (COORD_BITS)
  ) u_match (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rd_pend_q),
    .query_i (query_q),
    .ref_i   (ram_rdata),
    .tol_i   (tol_q),
    .res_o   (cmp_res)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign kept = ~hit_q;
  assign flag = change_seen_q | kept;

  always_comb begin
    state_d       = state_q;
    ref_count_d   = ref_count_q;
    issue_idx_d   = issue_idx_q;
    hit_d         = hit_q;
    change_seen_d = change_seen_q;
    out_load      = 1'b0;
    m_valid_d     = m_valid_q & ~m_axis_tready;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (s_axis_tuser)
            REQ_LOAD: begin
              if (ram_we) begin
                ref_count_d = ref_count_q + CntW'(1);
              end
            end
            REQ_QUERY: begin
              issue_idx_d = '0;
              hit_d       = 1'b0;
              state_d     = ST_SCAN;
            end
            REQ_CLEAR: begin
              ref_count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          issue_idx_d = issue_idx_q + CntW'(1);
        end
        if (cmp_res.valid && cmp_res.hit) begin
          hit_d = 1'b1;
        end
        // Finished once every stored point has been read and compared.
        if (!rd_en && !rd_pend_q && !cmp_res.valid) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load      = 1'b1;
          m_valid_d     = 1'b1;
          change_seen_d = last_q ? 1'b0 : flag;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      ref_count_q   <= '0;
      issue_idx_q   <= '0;
      rd_pend_q     <= 1'b0;
      hit_q         <= 1'b0;
      change_seen_q <= 1'b0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      ref_count_q   <= ref_count_d;
      issue_idx_q   <= issue_idx_d;
      rd_pend_q     <= rd_en;
      hit_q         <= hit_d;
      change_seen_q <= change_seen_d;
      m_valid_q     <= m_valid_d;
    end
  end

  // Query payload, held for the whole scan.
  always_ff @(posedge clk_i) begin
    if (in_fire && (s_axis_tuser == REQ_QUERY)) begin
      query_q  <= s_axis_tdata[PointW-1:0];
      intens_q <= s_axis_tdata[PointW +: IntensW];
      last_q   <= s_axis_tlast;
    end
  end

  // Output register; a result may wait here while the next item is taken.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= DataW'({intens_q, query_q});
      m_user_q <= {flag, kept};
      m_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ref_count_q <= CntW'(REF_DEPTH))
    else $error("reference count beyond store depth");

  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (state_q == ST_SCAN))
    else $error("store read outstanding outside a scan");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (s_axis_tuser == REQ_QUERY)) |=> !s_axis_tready)
    else $error("input taken while a query is being scanned");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_valid_q && m_valid_d) |-> (state_q == ST_DONE))
    else $error("result issued outside the completion state");

endmodule

// ===== hdl/psbd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module psbd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/psbd_match.sv =====
// ----------------------------------------------------------------------------
// Point set box difference - shared compare unit
// Checks one stored point per cycle against the query point: all three axis
// distances must lie within the tolerance. The outcome is registered.
// ----------------------------------------------------------------------------
module psbd_match
  import psbd_pkg::*;
#(
  parameter int COORD_BITS = CoordBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [3*COORD_BITS-1:0] query_i,
  input  logic [3*COORD_BITS-1:0] ref_i,
  input  logic [TolW-1:0]         tol_i,
  output cmp_res_t                res_o
);

  localparam int DiffW = COORD_BITS + 1;
  localparam int MagW  = (DiffW > TolW) ? DiffW : TolW;

  logic [2:0] axis_ok;
  cmp_res_t   res_q;

  always_comb begin
    logic [COORD_BITS-1:0] a;
    logic [COORD_BITS-1:0] b;
    logic [DiffW-1:0]      diff;
    logic [DiffW-1:0]      mag;
    for (int k = 0; k < 3; k++) begin
      a    = query_i[k*COORD_BITS +: COORD_BITS];
      b    = ref_i[k*COORD_BITS +: COORD_BITS];
      diff = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
      // The difference of two in-range values never reaches the most
      // negative code, so negating it is always exact.
      mag  = diff[DiffW-1] ? (~diff + DiffW'(1)) : diff;
      axis_ok[k] = (MagW'(mag) <= MagW'(tol_i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q.valid <= valid_i;
      res_q.hit   <= valid_i & (&axis_ok);
    end
  end

  assign res_o = res_q;

endmodule

// ===== dv/point_set_box_difference_tb.sv =====
// ----------------------------------------------------------------------------
// Point set box difference - testbench
// Streams reference loads, clears and query frames into the block and checks
// each result against a predictor that models the store, the tolerance and
// the frame flag. The tolerance register is written and read back between
// phases, and both streams idle and stall at random in all but the last phase.
// ----------------------------------------------------------------------------
module point_set_box_difference_tb
  import psbd_pkg::*;
();

  localparam int CW         = CoordBitsDef;
  localparam int Depth      = RefDepthDef;
  localparam int DataW      = ((3 * CW + IntensW + 7) / 8) * 8;
  localparam int StallLimit = 20000;

  localparam logic [ReqW-1:0]     ReqUnused = 2'd3;
  localparam logic [ApbAddrW-1:0] TolAddr   = {RegTolIdx, 2'b00};

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t CoordMax = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t CoordMin = {1'b1, {(CW-1){1'b0}}};

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct {
    logic [ReqW-1:0]    req;
    point_t             pt;
    logic [IntensW-1:0] intens;
    logic               last;
  } request_t;

  typedef struct {
    logic               kept;
    point_t             pt;
    logic [IntensW-1:0] intens;
    logic               changed;
    logic               last;
  } outcome_t;

  class frame_diff_scoreboard;
    point_t          ref_store[Depth];
    int unsigned     stored;
    bit              change_seen;
    logic [TolW-1:0] tol;
    outcome_t        expected_q[$];
    int              errors;

    function new();
      stored      = 0;
      change_seen = 1'b0;
      tol         = TolReset;
      errors      = 0;
    endfunction

    task report(string msg);
      if (errors < 50) begin
        $display("MISMATCH at %0t: %s", $time, msg);
      end
      errors++;
    endtask

    function bit axis_near(coord_t a, coord_t b);
      int d;
      d = int'(a) - int'(b);
      if (d < 0) begin
        d = -d;
      end
      return d <= int'(tol);
    endfunction

    function void note_request(request_t r);
      outcome_t o;
      bit       hit;
      hit = 1'b0;
      case (r.req)
        REQ_LOAD: begin
          // A full store ignores further loads.
          if (stored < Depth) begin
            ref_store[stored] = r.pt;
            stored++;
          end
        end
        REQ_CLEAR: begin
          stored = 0;
        end
        REQ_QUERY: begin
          for (int i = 0; i < int'(stored) && !hit; i++) begin
            hit = axis_near(r.pt.x, ref_store[i].x) && axis_near(r.pt.y, ref_store[i].y) &&
                  axis_near(r.pt.z, ref_store[i].z);
          end
          o.kept    = !hit;
          o.pt      = r.pt;
          o.intens  = r.intens;
          o.changed = change_seen || o.kept;
          o.last    = r.last;
          expected_q = {expected_q, o};
          change_seen = r.last ? 1'b0 : o.changed;
        end
        default: begin
        end
      endcase
    endfunction

    task check_result(outcome_t got);
      outcome_t want;
      if (expected_q.size() == 0) begin
        report("result transaction with no query waiting");
        return;
      end
      want = expected_q.pop_front();
      if (got.kept !== want.kept)
        report($sformatf("kept %b, expected %b", got.kept, want.kept));
      if (got.pt.x !== want.pt.x)
        report($sformatf("out_x %0d, expected %0d", got.pt.x, want.pt.x));
      if (got.pt.y !== want.pt.y)
        report($sformatf("out_y %0d, expected %0d", got.pt.y, want.pt.y));
      if (got.pt.z !== want.pt.z)
        report($sformatf("out_z %0d, expected %0d", got.pt.z, want.pt.z));
      if (got.intens !== want.intens)
        report($sformatf("out_intensity %h, expected %h", got.intens, want.intens));
      if (got.changed !== want.changed)
        report($sformatf("frame_has_change %b, expected %b", got.changed, want.changed));
      if (got.last !== want.last)
        report($sformatf("out_last %b, expected %b", got.last, want.last));
    endtask
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [DataW-1:0]    s_axis_tdata  = '0;
  logic [ReqW-1:0]     s_axis_tuser  = '0;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [DataW-1:0]    m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;
  logic                m_axis_tlast;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [ApbAddrW-1:0] paddr         = '0;
  logic [ApbDataW-1:0] pwdata        = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  frame_diff_scoreboard sb;
  int send_idle_pct  = 25;
  int recv_stall_pct = 48;
  int quiet_cycles   = 0;

  point_set_box_difference #(
    .REF_DEPTH (Depth),
    .COORD_BITS(CW)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Result side: check every accepted transaction, then choose the next stall.
  always @(posedge clk_i) begin
    outcome_t got;
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      got.pt.x    = m_axis_tdata[CW-1:0];
      got.pt.y    = m_axis_tdata[2*CW-1:CW];
      got.pt.z    = m_axis_tdata[3*CW-1:2*CW];
      got.intens  = m_axis_tdata[3*CW+IntensW-1:3*CW];
      got.kept    = m_axis_tuser[0];
      got.changed = m_axis_tuser[1];
      got.last    = m_axis_tlast;
      sb.check_result(got);
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic point_t pt(coord_t x, coord_t y, coord_t z);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    return p;
  endfunction

  function automatic request_t mk(logic [ReqW-1:0] req, point_t p, logic [IntensW-1:0] intens,
                                  logic last);
    request_t r;
    r.req    = req;
    r.pt     = p;
    r.intens = intens;
    r.last   = last;
    return r;
  endfunction

  function automatic coord_t random_coord(bit wide);
    int sel;
    sel = wide ? 5 : $urandom_range(9);
    if (sel < 5) begin
      // A narrow cluster makes neighbouring points fall within tolerance.
      return coord_t'(int'($urandom_range(4000)) - 2000);
    end else if (sel < 9) begin
      return coord_t'($urandom);
    end
    return $urandom_range(1) ? CoordMax : CoordMin;
  endfunction

  function automatic point_t random_point(bit wide);
    return pt(random_coord(wide), random_coord(wide), random_coord(wide));
  endfunction

  // Offsets sit on the tolerance boundary often; in_box_only keeps them within it.
  function automatic coord_t near_coord(coord_t c, bit in_box_only);
    int t;
    int off;
    t = int'(sb.tol);
    if (in_box_only) begin
      off = int'($urandom_range(2 * t)) - t;
    end else begin
      case ($urandom_range(4))
        0: off = -t - 1;
        1: off = -t;
        2: off = t;
        3: off = t + 1;
        default: off = int'($urandom_range(2 * t + 4)) - t - 2;
      endcase
    end
    return coord_t'(int'(c) + off);
  endfunction

  task automatic send_item(request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(DataW-3*CW-IntensW){1'b0}}, r.intens, r.pt.z, r.pt.y, r.pt.x};
    s_axis_tuser  <= r.req;
    s_axis_tlast  <= r.last;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sb.note_request(r);
  endtask

  task automatic send_query(bit last, bit in_box_only);
    point_t p;
    int     k;
    if (sb.stored != 0 && (in_box_only || $urandom_range(9) < 6)) begin
      k   = $urandom_range(sb.stored - 1);
      p.x = near_coord(sb.ref_store[k].x, in_box_only);
      p.y = near_coord(sb.ref_store[k].y, in_box_only);
      p.z = near_coord(sb.ref_store[k].z, in_box_only);
    end else begin
      p = random_point(1'b0);
    end
    send_item(mk(REQ_QUERY, p, IntensW'($urandom_range(65535)), last));
  endtask

  task automatic apb_xfer(input logic wr, input logic [ApbDataW-1:0] wdata,
                          output logic [ApbDataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= TolAddr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_tol_readback();
    logic [ApbDataW-1:0] rd;
    apb_xfer(1'b0, '0, rd);
    if (rd !== ApbDataW'(sb.tol)) begin
      sb.report($sformatf("tolerance reads %0d, expected %0d", rd, sb.tol));
    end
  endtask

  task automatic write_tol(logic [TolW-1:0] val);
    logic [ApbDataW-1:0] rd;
    apb_xfer(1'b1, ApbDataW'(val), rd);
    sb.tol = val;
    check_tol_readback();
  endtask

  // Waits for every outstanding result, then lets a trailing load complete.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic random_phase(int n_items);
    int       sent;
    int       n_frames;
    int       n_queries;
    bit       in_box_only;
    request_t r;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 15) begin
        r = mk(ReqW'($urandom_range(3)), random_point(1'($urandom_range(1))),
               IntensW'($urandom_range(65535)), 1'($urandom_range(1)));
        send_item(r);
        if (r.req != ReqUnused) begin
          sent++;
        end
      end else begin
        if ($urandom_range(1)) begin
          send_item(mk(REQ_CLEAR, random_point(1'b1), IntensW'($urandom_range(65535)),
                       1'($urandom_range(1))));
          sent++;
        end
        repeat ($urandom_range(10)) begin
          send_item(mk(REQ_LOAD, random_point(1'b0), IntensW'($urandom_range(65535)),
                       1'($urandom_range(1))));
          sent++;
        end
        n_frames = $urandom_range(1, 3);
        repeat (n_frames) begin
          n_queries   = $urandom_range(1, 6);
          in_box_only = ($urandom_range(3) == 0);
          for (int q = 1; q <= n_queries; q++) begin
            send_query(q == n_queries, in_box_only);
            sent++;
          end
        end
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_tol_readback();

    // Directed part at the reset tolerance of 100 mm.
    send_item(mk(REQ_QUERY, pt(CoordMax, CoordMin, CoordMax), 16'hFFFF, 1'b0));
    send_item(mk(REQ_LOAD, pt(0, 0, 0), 16'h0000, 1'b0));
    send_item(mk(REQ_QUERY, pt(100, -100, 100), 16'h0000, 1'b0));
    send_item(mk(REQ_QUERY, pt(101, 0, 0), 16'h5A5A, 1'b0));
    send_item(mk(REQ_QUERY, pt(0, -101, 0), 16'hA5A5, 1'b0));
    send_item(mk(REQ_QUERY, pt(0, 0, 101), 16'h0001, 1'b1));
    send_item(mk(REQ_LOAD, pt(CoordMax, CoordMin, CoordMax), 16'hFFFF, 1'b1));
    send_item(mk(REQ_QUERY, pt(coord_t'(CoordMax - 100), coord_t'(CoordMin + 100),
                               coord_t'(CoordMax - 100)), 16'h8000, 1'b1));
    send_item(mk(ReqUnused, random_point(1'b1), 16'h1234, 1'b1));
    send_item(mk(REQ_QUERY, pt(0, 0, 0), 16'h00FF, 1'b0));
    // A clear in mid-frame keeps the frame flag.
    send_item(mk(REQ_CLEAR, pt(CoordMax, CoordMax, CoordMax), 16'hFFFF, 1'b1));
    send_item(mk(REQ_QUERY, pt(0, 0, 0), 16'hFF00, 1'b1));
    send_item(mk(REQ_QUERY, pt(CoordMin, CoordMin, CoordMin), 16'hFFFF, 1'b1));
    send_item(mk(REQ_LOAD, pt(CoordMin, CoordMax, CoordMin), 16'h0000, 1'b0));
    send_item(mk(REQ_QUERY, pt(CoordMin, CoordMax, CoordMin), 16'h0000, 1'b1));
    settle();

    write_tol('0);
    send_item(mk(REQ_LOAD, pt(1000, -1000, 12345), 16'h0000, 1'b0));
    send_item(mk(REQ_QUERY, pt(1000, -1000, 12345), 16'h0F0F, 1'b0));
    send_item(mk(REQ_QUERY, pt(1001, -1000, 12345), 16'hF0F0, 1'b1));
    settle();

    write_tol({TolW{1'b1}});
    send_item(mk(REQ_QUERY, pt(1000 + 1023, -1000 - 1023, 12345 + 1023), 16'h0000, 1'b0));
    send_item(mk(REQ_QUERY, pt(1000 - 1024, -1000, 12345), 16'h0000, 1'b1));
    // Opposite extremes are far apart; the distance must not wrap.
    send_item(mk(REQ_QUERY, pt(CoordMax, CoordMin, CoordMax), 16'hFFFF, 1'b1));
    send_item(mk(REQ_CLEAR, pt(0, 0, 0), 16'h0000, 1'b0));
    settle();

    write_tol(TolW'($urandom_range(300)));
    random_phase(185);
    settle();

    send_idle_pct  = 48;
    recv_stall_pct = 25;
    write_tol($urandom_range(1) ? TolW'($urandom_range(1023)) : TolW'($urandom_range(40)));
    random_phase(185);
    settle();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_tol(TolW'($urandom_range(300)));
    random_phase(185);
    settle();

    repeat (sb.stored + 8) @(posedge clk_i);
    if (sb.expected_q.size() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
    end
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/psbd_pkg.sv
hdl/psbd_ram.sv
hdl/psbd_match.sv
hdl/point_set_box_difference.sv
dv/point_set_box_difference_tb.sv
